FILE: design/fol_pkg.sv
// Shared types, field widths and codes of the frequency-ordered list.
package fol_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int POS_W    = 4;
   localparam int HIT_W    = 16;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
   localparam logic [STATUS_W-1:0] ST_HIT      = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISS     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

   // Commands from the controller to the datapath, one step per cycle; the load step waits for a free output register.
   typedef struct packed {
      logic latch;
      logic search;
      logic pick;
      logic scan;
      logic move;
      logic load;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic lookup;
      logic found;
   } stat_type;

endpackage

FILE: design/fol_req_if.sv
// Request channel interface: command and value.
interface fol_req_if;
   logic                        valid;
   logic                        ready;
   logic                        cmd;
   logic [fol_pkg::VALUE_W-1:0] value;

   modport source (output valid, output cmd, output value, input ready);
   modport sink   (input valid, input cmd, input value, output ready);
endinterface

FILE: design/fol_rsp_if.sv
// Response channel interface: status, position and hit count.
interface fol_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fol_pkg::STATUS_W-1:0] status;
   logic [fol_pkg::POS_W-1:0]    position;
   logic [fol_pkg::HIT_W-1:0]    hit_count;

   modport source (output valid, output status, output position, output hit_count,
                   input ready);
   modport sink   (input valid, input status, input position, input hit_count,
                   output ready);
endinterface

FILE: design/fol_ctrl.sv
// Controller state machine that sequences one command at a time.
module fol_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  fol_pkg::stat_type stat,
   output fol_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_PICK   = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_MOVE   = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_SEARCH;
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = stat.lookup ? S_PICK : S_DONE;
         end
         S_PICK: begin
            cmd.pick = 1'b1;
            state_in = stat.found ? S_SCAN : S_DONE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            state_in = S_MOVE;
         end
         S_MOVE: begin
            cmd.move = 1'b1;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: design/fol_datapath.sv
// Datapath: the row of list cells, match and order logic, and the result register.
module fol_datapath #(
   parameter int DEPTH      = fol_pkg::DEPTH_DEFAULT,
   parameter int COUNT_BITS = fol_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fol_pkg::cmd_type              cmd,
   output fol_pkg::stat_type             stat,
   input  logic                          req_cmd,
   input  logic [fol_pkg::VALUE_W-1:0]   req_value,
   output logic [fol_pkg::STATUS_W-1:0]  rsp_status,
   output logic [fol_pkg::POS_W-1:0]     rsp_position,
   output logic [fol_pkg::HIT_W-1:0]     rsp_hit_count
);

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   logic [fol_pkg::VALUE_W-1:0] val_ff [DEPTH];
   logic [COUNT_BITS-1:0]       cnt_ff [DEPTH];
   logic [FILL_W-1:0]           fill_ff;

   logic                        op_ff;
   logic [fol_pkg::VALUE_W-1:0] key_ff;
   logic [DEPTH-1:0]            hit_ff;
   logic [IDX_W-1:0]            pos_ff;
   logic [IDX_W-1:0]            dest_ff;
   logic [COUNT_BITS-1:0]       work_cnt_ff;
   logic [fol_pkg::STATUS_W-1:0] res_status_ff;

   logic [fol_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [fol_pkg::POS_W-1:0]    rsp_position_ff;
   logic [fol_pkg::HIT_W-1:0]    rsp_hit_count_ff;

   logic                  full;
   logic                  found;
   logic [IDX_W-1:0]      first_pos;
   logic [COUNT_BITS-1:0] sel_cnt;
   logic [COUNT_BITS-1:0] next_cnt;
   logic [DEPTH-1:0]      match;
   logic [IDX_W-1:0]      dest;
   logic [31:0]           pos_ext;
   logic [31:0]           cnt_ext;

   assign full        = (fill_ff == FILL_W'(DEPTH));
   assign found       = |hit_ff;
   assign stat.lookup = (op_ff == fol_pkg::CMD_LOOKUP);
   assign stat.found  = found;

   // Parallel compare of every filled cell against the key.
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         match[k] = (k < int'(fill_ff)) && (val_ff[k] == key_ff);
      end
   end

   // First hit from the front, and its count selected through the hit vector masked to that position.
   always_comb begin
      first_pos = '0;
      sel_cnt   = '0;
      for (int k = DEPTH - 1; k >= 0; k--) begin
         if (hit_ff[k]) begin
            first_pos = IDX_W'(k);
         end
      end
      for (int k = 0; k < DEPTH; k++) begin
         if (hit_ff[k] && (IDX_W'(k) == first_pos)) begin
            sel_cnt = sel_cnt | cnt_ff[k];
         end
      end
      next_cnt = (sel_cnt == COUNT_MAX) ? sel_cnt : sel_cnt + 1'b1;
   end

   // The entry lands just behind the last earlier cell whose count is not smaller.
   always_comb begin
      dest = '0;
      for (int k = 0; k < DEPTH; k++) begin
         if ((k < int'(pos_ff)) && !(cnt_ff[k] < work_cnt_ff)) begin
            dest = IDX_W'(k + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.search && (op_ff == fol_pkg::CMD_INSERT) && !full) begin
         fill_ff <= fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff  <= req_cmd;
         key_ff <= req_value;
      end
      if (cmd.search) begin
         hit_ff      <= match;
         work_cnt_ff <= '0;
         pos_ff      <= '0;
         if (op_ff == fol_pkg::CMD_INSERT) begin
            res_status_ff <= full ? fol_pkg::ST_FULL : fol_pkg::ST_INSERTED;
         end
      end
      if (cmd.pick) begin
         if (found) begin
            res_status_ff <= fol_pkg::ST_HIT;
            pos_ff        <= first_pos;
            work_cnt_ff   <= next_cnt;
         end else begin
            res_status_ff <= fol_pkg::ST_MISS;
         end
      end
      if (cmd.scan) begin
         dest_ff <= dest;
      end
   end

   // List cells: append at the fill point, or rotate the hit entry forward.
   always_ff @(posedge clock) begin
      for (int k = 0; k < DEPTH; k++) begin
         if (cmd.search && (op_ff == fol_pkg::CMD_INSERT) && !full &&
             (k == int'(fill_ff))) begin
            val_ff[k] <= key_ff;
            cnt_ff[k] <= '0;
         end else if (cmd.move) begin
            if (k == int'(dest_ff)) begin
               val_ff[k] <= key_ff;
               cnt_ff[k] <= work_cnt_ff;
            end else if ((k > int'(dest_ff)) && (k <= int'(pos_ff))) begin
               val_ff[k] <= val_ff[k-1];
               cnt_ff[k] <= cnt_ff[k-1];
            end
         end
      end
   end

   assign pos_ext = 32'(pos_ff);
   assign cnt_ext = 32'(work_cnt_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_status_ff    <= res_status_ff;
         rsp_position_ff  <= pos_ext[fol_pkg::POS_W-1:0];
         rsp_hit_count_ff <= cnt_ext[fol_pkg::HIT_W-1:0];
      end
   end

   assign rsp_status    = rsp_status_ff;
   assign rsp_position  = rsp_position_ff;
   assign rsp_hit_count = rsp_hit_count_ff;

endmodule

FILE: design/frequency_ordered_list.sv
// Top level of the frequency-ordered list: controller plus datapath.
//
// A request carries cmd and value. An insert appends value at the tail with
// count zero, or reports the list full. A lookup finds the first matching
// entry from the front, reports its position, bumps its count (saturating) and
// moves it ahead of the run of earlier entries with a strictly smaller count.
// Each request yields exactly one response on the rsp channel.
//
// One request is worked on at a time. After the request transfer an insert
// steps through the search and done states, a lookup miss through search,
// pick and done, and a lookup hit through search, pick, scan, move and done;
// these steps are the match compare over all cells, the first-hit select,
// the insertion point search and the shift of the cell row. The next request
// is taken in the idle state that follows the load of the response, and a
// new request can be accepted while an earlier response still waits in the
// output register. If the receiver stalls with a response pending, the next
// response waits in its final step until the output register frees up.
// Reset empties the list, returns the controller to idle and clears the response valid.
module frequency_ordered_list #(
   parameter int DEPTH      = fol_pkg::DEPTH_DEFAULT,
   parameter int COUNT_BITS = fol_pkg::COUNT_BITS_DEFAULT
) (
   input  logic     clock,
   input  logic     reset,
   fol_req_if.sink  req_chan,
   fol_rsp_if.source rsp_chan
);

   fol_pkg::cmd_type  cmd;
   fol_pkg::stat_type stat;

   fol_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   fol_datapath #(
      .DEPTH      (DEPTH),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_cmd       (req_chan.cmd),
      .req_value     (req_chan.value),
      .rsp_status    (rsp_chan.status),
      .rsp_position  (rsp_chan.position),
      .rsp_hit_count (rsp_chan.hit_count)
   );

endmodule

FILE: design/fol_checker.sv
// Port-level checks of the frequency-ordered list, bound to the top level.
module fol_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [fol_pkg::STATUS_W-1:0]  rsp_status,
   input logic [fol_pkg::POS_W-1:0]     rsp_position,
   input logic [fol_pkg::HIT_W-1:0]     rsp_hit_count
);

   // A pending response stays up until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   // A stalled response keeps its payload.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_status) && $stable(rsp_position) && $stable(rsp_hit_count))
      else $error("response payload changed while stalled");

   // Only a hit reports a position and a count.
   a_non_hit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != fol_pkg::ST_HIT) |->
         (rsp_position == '0) && (rsp_hit_count == '0))
      else $error("non-hit response carries position or count");

   // After a request transfer the block is busy and takes no second request.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a command is in progress");

endmodule

bind frequency_ordered_list fol_checker u_fol_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_status    (rsp_chan.status),
   .rsp_position  (rsp_chan.position),
   .rsp_hit_count (rsp_chan.hit_count)
);

FILE: tb/sv/testbench.sv
// Self-checking testbench of the frequency-ordered list with directed, random and hot-entry traffic.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     DEPTH        = fol_pkg::DEPTH_DEFAULT;
   localparam int     COUNT_BITS   = fol_pkg::COUNT_BITS_DEFAULT;
   localparam int     VALUE_W      = fol_pkg::VALUE_W;
   localparam int     STATUS_W     = fol_pkg::STATUS_W;
   localparam int     POS_W        = fol_pkg::POS_W;
   localparam int     HIT_W        = fol_pkg::HIT_W;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam int     RANDOM_FIRST = 400;
   localparam int     HOT_ROUNDS   = 40;
   localparam int     RANDOM_LAST  = 390;
   localparam int     HOLD_AFTER   = 60;
   localparam int     HOLD_CYCLES  = 250;
   localparam int     DRAIN_CYCLES = 20;
   localparam int     MAX_REPORTS  = 20;
   localparam longint CYCLE_LIMIT  = 100_000;
   localparam bit     FROM_TABLE   = 1'b1;
   localparam bit     FROM_MODEL   = 1'b0;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [POS_W-1:0]    position;
      logic [HIT_W-1:0]    hit_count;
   } answer_type;

   typedef struct {
      logic               cmd;
      logic [VALUE_W-1:0] value;
      bit                 from_table;
      answer_type         answer;
   } request_row_type;

   logic   clock = 1'b0;
   logic   reset;
   longint cycles = 0;

   fol_req_if req_chan ();
   fol_rsp_if rsp_chan ();

   frequency_ordered_list #(
      .DEPTH      (DEPTH),
      .COUNT_BITS (COUNT_BITS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5ns clock = ~clock;

   // Mirror of the list contents, kept in step with every accepted transfer.
   logic [VALUE_W-1:0]    list_value [DEPTH];
   logic [COUNT_BITS-1:0] list_count [DEPTH];
   int                    list_fill = 0;

   answer_type      answers_due [$];
   request_row_type directed_rows [$];

   bit               steady = 1'b0;
   int               failures = 0;
   int               reports = 0;
   int               responses_taken = 0;
   int               n_inserted = 0;
   int               n_full = 0;
   int               n_hit = 0;
   int               n_miss = 0;
   logic [HIT_W-1:0] top_count = '0;

   function automatic int find_first(input logic [VALUE_W-1:0] value);
      for (int i = 0; i < list_fill; i++)
         if (list_value[i] == value) return i;
      return -1;
   endfunction

   // Applies one request to the mirrored list and returns the response it should produce.
   function automatic answer_type list_access(input logic cmd,
                                              input logic [VALUE_W-1:0] value);
      answer_type            result;
      int                    at;
      int                    dest;
      logic [COUNT_BITS-1:0] bumped;
      result = '{status: fol_pkg::ST_MISS, position: '0, hit_count: '0};
      if (cmd == fol_pkg::CMD_INSERT) begin
         if (list_fill >= DEPTH) begin
            result.status = fol_pkg::ST_FULL;
         end else begin
            list_value[list_fill] = value;
            list_count[list_fill] = '0;
            list_fill++;
            result.status = fol_pkg::ST_INSERTED;
         end
      end else begin
         at = find_first(value);
         if (at >= 0) begin
            bumped = list_count[at];
            if (bumped != COUNT_MAX) bumped++;
            dest = at;
            while (dest > 0 && list_count[dest-1] < bumped) dest--;
            for (int k = at; k > dest; k--) begin
               list_value[k] = list_value[k-1];
               list_count[k] = list_count[k-1];
            end
            list_value[dest] = value;
            list_count[dest] = bumped;
            result.status    = fol_pkg::ST_HIT;
            result.position  = POS_W'(at);
            result.hit_count = HIT_W'(bumped);
         end
      end
      return result;
   endfunction

   function automatic void row(input logic cmd, input logic [VALUE_W-1:0] value,
                               input bit from_table, input logic [STATUS_W-1:0] status,
                               input int position, input int hits);
      request_row_type r;
      r.cmd        = cmd;
      r.value      = value;
      r.from_table = from_table;
      r.answer     = '{status: status, position: POS_W'(position), hit_count: HIT_W'(hits)};
      directed_rows.push_back(r);
   endfunction

   // Offers one request, waits for its transfer, then records what it should return.
   task automatic send_item(input logic cmd, input logic [VALUE_W-1:0] value,
                            input bit from_table, input answer_type typed);
      answer_type predicted;
      while (!steady && $urandom_range(0, 99) < 16) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.cmd   <= cmd;
      req_chan.value <= value;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      predicted = list_access(cmd, value);
      answers_due.push_back(from_table ? typed : predicted);
   endtask

   // Mostly lookups of stored values, with the tail favored so that entries travel far.
   task automatic random_request();
      int                 roll;
      int                 pick;
      logic [VALUE_W-1:0] value;
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, list_fill - 1);
      if (roll < 40) begin
         send_item(fol_pkg::CMD_LOOKUP, list_value[pick], FROM_MODEL, '0);
      end else if (roll < 65) begin
         pick = $urandom_range(list_fill / 2, list_fill - 1);
         send_item(fol_pkg::CMD_LOOKUP, list_value[pick], FROM_MODEL, '0);
      end else if (roll < 80) begin
         send_item(fol_pkg::CMD_LOOKUP, $urandom, FROM_MODEL, '0);
      end else if (roll < 88) begin
         value = list_value[pick] ^ (32'd1 << $urandom_range(0, VALUE_W - 1));
         send_item(fol_pkg::CMD_LOOKUP, value, FROM_MODEL, '0);
      end else begin
         send_item(fol_pkg::CMD_INSERT, $urandom, FROM_MODEL, '0);
      end
   endtask

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         failures++;
         if (reports < MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         reports++;
      end
   endfunction

   initial begin : stimulus
      int                 target;
      logic [VALUE_W-1:0] hot_value;
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.cmd   <= fol_pkg::CMD_INSERT;
      req_chan.value <= '0;

      //   command              value          source      status                pos  count
      row(fol_pkg::CMD_LOOKUP, 32'h0000_0000, FROM_TABLE, fol_pkg::ST_MISS,      0,   0);
      row(fol_pkg::CMD_INSERT, 32'h8000_0000, FROM_TABLE, fol_pkg::ST_INSERTED,  0,   0);
      row(fol_pkg::CMD_INSERT, 32'h7FFF_FFFF, FROM_TABLE, fol_pkg::ST_INSERTED,  0,   0);
      row(fol_pkg::CMD_INSERT, 32'h0000_0000, FROM_TABLE, fol_pkg::ST_INSERTED,  0,   0);
      row(fol_pkg::CMD_INSERT, 32'hFFFF_FFFF, FROM_TABLE, fol_pkg::ST_INSERTED,  0,   0);
      row(fol_pkg::CMD_INSERT, 32'h0000_0005, FROM_TABLE, fol_pkg::ST_INSERTED,  0,   0);
      row(fol_pkg::CMD_INSERT, 32'h0000_0005, FROM_TABLE, fol_pkg::ST_INSERTED,  0,   0);
      row(fol_pkg::CMD_LOOKUP, 32'h0000_0005, FROM_TABLE, fol_pkg::ST_HIT,       4,   1);
      row(fol_pkg::CMD_LOOKUP, 32'h0000_0005, FROM_MODEL, fol_pkg::ST_HIT,       0,   0);
      row(fol_pkg::CMD_LOOKUP, 32'h7FFF_FFFE, FROM_TABLE, fol_pkg::ST_MISS,      0,   0);
      row(fol_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, FROM_MODEL, fol_pkg::ST_HIT,       0,   0);
      row(fol_pkg::CMD_LOOKUP, 32'h8000_0000, FROM_MODEL, fol_pkg::ST_HIT,       0,   0);
      row(fol_pkg::CMD_INSERT, 32'h0000_0001, FROM_TABLE, fol_pkg::ST_INSERTED,  0,   0);
      row(fol_pkg::CMD_INSERT, 32'h0000_0002, FROM_TABLE, fol_pkg::ST_INSERTED,  0,   0);
      row(fol_pkg::CMD_INSERT, 32'h0000_0003, FROM_TABLE, fol_pkg::ST_INSERTED,  0,   0);
      row(fol_pkg::CMD_INSERT, 32'h5555_5555, FROM_TABLE, fol_pkg::ST_INSERTED,  0,   0);
      row(fol_pkg::CMD_INSERT, 32'hAAAA_AAAA, FROM_TABLE, fol_pkg::ST_INSERTED,  0,   0);
      row(fol_pkg::CMD_INSERT, 32'h0001_0000, FROM_TABLE, fol_pkg::ST_INSERTED,  0,   0);
      row(fol_pkg::CMD_INSERT, 32'hFFFF_0000, FROM_TABLE, fol_pkg::ST_INSERTED,  0,   0);
      row(fol_pkg::CMD_INSERT, 32'h0000_FFFF, FROM_TABLE, fol_pkg::ST_INSERTED,  0,   0);
      row(fol_pkg::CMD_INSERT, 32'h1234_5678, FROM_TABLE, fol_pkg::ST_INSERTED,  0,   0);
      row(fol_pkg::CMD_INSERT, 32'h0F0F_0F0F, FROM_TABLE, fol_pkg::ST_INSERTED,  0,   0);
      row(fol_pkg::CMD_INSERT, 32'h0000_0007, FROM_TABLE, fol_pkg::ST_FULL,      0,   0);
      row(fol_pkg::CMD_INSERT, 32'h8000_0000, FROM_TABLE, fol_pkg::ST_FULL,      0,   0);
      row(fol_pkg::CMD_LOOKUP, 32'h0F0F_0F0F, FROM_TABLE, fol_pkg::ST_HIT,       15,  1);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].cmd, directed_rows[i].value,
                   directed_rows[i].from_table, directed_rows[i].answer);

      repeat (RANDOM_FIRST) random_request();

      // Hammer one entry from the back of the list with no idling on either side.
      // The second copy of a duplicate can never be hit, so it is skipped as a target.
      target = -1;
      for (int i = list_fill - 1; i >= 0 && target < 0; i--)
         if (find_first(list_value[i]) == i) target = i;
      hot_value = list_value[target];
      steady    = 1'b1;
      repeat (HOT_ROUNDS) send_item(fol_pkg::CMD_LOOKUP, hot_value, FROM_MODEL, '0);
      steady = 1'b0;

      repeat (RANDOM_LAST) random_request();
      req_chan.valid <= 1'b0;

      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d responses checked: %0d inserted, %0d rejected full, %0d hits, %0d misses",
               responses_taken, n_inserted, n_full, n_hit, n_miss);
      $display("highest access count %0d; responses held off for %0d cycles once",
               top_count, HOLD_CYCLES);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   initial begin : response_side
      int         hold_left;
      answer_type got;
      answer_type want;
      hold_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            got = '{status: rsp_chan.status, position: rsp_chan.position,
                    hit_count: rsp_chan.hit_count};
            responses_taken++;
            case (got.status)
               fol_pkg::ST_INSERTED: n_inserted++;
               fol_pkg::ST_FULL:     n_full++;
               fol_pkg::ST_HIT:      n_hit++;
               default:              n_miss++;
            endcase
            if (got.hit_count > top_count) top_count = got.hit_count;
            if (answers_due.size() == 0) begin
               failures++;
               if (reports < MAX_REPORTS)
                  $display("%0t: unexpected response, expected none, actual %0h",
                           $time, got);
               reports++;
            end else begin
               want = answers_due.pop_front();
               check_field("status", 32'(want.status), 32'(got.status));
               check_field("position", 32'(want.position), 32'(got.position));
               check_field("hit_count", 32'(want.hit_count), 32'(got.hit_count));
            end
            // Stop taking responses for a while so the block backs up into its input.
            if (responses_taken == HOLD_AFTER) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= steady || ($urandom_range(0, 99) >= 16);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d responses outstanding",
                  $time, cycles, answers_due.size());
         $display("status: fail");
         $finish;
      end
   end

endmodule

FILE: frequency_ordered_list.f
design/fol_pkg.sv
design/fol_req_if.sv
design/fol_rsp_if.sv
design/fol_ctrl.sv
design/fol_datapath.sv
design/frequency_ordered_list.sv
design/fol_checker.sv
tb/sv/testbench.sv
